[sv/psdmx_pkg.sv]
// ============================================================================
// psdmx_pkg
// Shared types and constants for the program stream PES demultiplexer.
// ============================================================================
package psdmx_pkg;

    typedef enum logic [3:0] {
        PH_HUNT     = 4'd0,
        PH_CODE     = 4'd1,
        PH_PACK1ST  = 4'd2,
        PH_PACKSKIP = 4'd3,
        PH_PACK2    = 4'd4,
        PH_LENHI    = 4'd5,
        PH_LENLO    = 4'd6,
        PH_SKIP     = 4'd7,
        PH_HDR1ST   = 4'd8,
        PH_STD2     = 4'd9,
        PH_AFTERSTD = 4'd10,
        PH_TS1      = 4'd11,
        PH_M2FLAGS2 = 4'd12,
        PH_M2HLEN   = 4'd13,
        PH_M2HDR    = 4'd14,
        PH_PAYLOAD  = 4'd15
    } phase_t;

    localparam int TS_W = 33;
    typedef logic [TS_W-1:0] ts_t;

    localparam logic [7:0] PACK_START_CODE = 8'hBA;
    localparam logic [7:0] FIRST_STREAM_ID = 8'hBB;
    localparam logic [7:0] STUFFING_BYTE   = 8'hFF;
    localparam logic [7:0] MPEG1_NO_TS     = 8'h0F;
    localparam logic [7:0] TARGET_RESET    = 8'hE0;
    localparam logic [7:0] HI2_MASK        = 8'hC0;
    localparam logic [7:0] HI4_MASK        = 8'hF0;
    localparam logic [7:0] MPEG2_MARK      = 8'h40;
    localparam logic [7:0] STD_MARK        = 8'h40;
    localparam logic [7:0] M1_PTS_MARK     = 8'h20;
    localparam logic [7:0] M1_PTSDTS_MARK  = 8'h30;
    localparam logic [7:0] M2_HDR_MARK     = 8'h80;
    localparam logic [7:0] M2_PTS_FLAGS    = 8'h80;
    localparam logic [7:0] M2_PTSDTS_FLAGS = 8'hC0;

    localparam logic [3:0] NEED_NONE   = 4'd0;
    localparam logic [3:0] NEED_PTS    = 4'd5;
    localparam logic [3:0] NEED_PTSDTS = 4'd10;

endpackage

[sv/program_stream_pes_demux_unit.sv]
// ============================================================================
// program_stream_pes_demux_unit
// Byte-serial MPEG-1/MPEG-2 program stream parser that passes on the payload
// bytes of one PES stream id together with its timestamps.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | data_byte
//  output   | out_valid / out_ready| payload_byte, packet_first, packet_last,
//           |                      | timestamp_valid, presentation_time,
//           |                      | decode_time
//  config   | cfg_wr_en            | cfg_wr_data (target stream id)
//
// Each stream byte is taken into an input register and parsed from there, so
// one beat is accepted per clock while the output is not stalled, and a
// payload beat passes through the input register and then the output register.
// Reset puts the parser in start code hunting with target id 0xE0.
// A stalled output holds the parse stage, and input ready falls only when the
// input register is full and cannot move on.
module program_stream_pes_demux_unit
    import psdmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        packet_first,
    output logic        packet_last,
    output logic        timestamp_valid,
    output ts_t         presentation_time,
    output ts_t         decode_time,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    function automatic ts_t ts_shift(input ts_t acc, input logic [2:0] pos,
                                     input logic [7:0] b);
        ts_t r;
        if (pos == 3'd0) begin
            r = {30'd0, b[3:1]};
        end else if (pos == 3'd1 || pos == 3'd3) begin
            r = {acc[TS_W-9:0], b};
        end else begin
            r = {acc[TS_W-8:0], b[7:1]};
        end
        return r;
    endfunction

    logic [7:0]  target_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg, phase_next;
    logic [1:0]  prefix_reg, prefix_next;
    logic [3:0]  fpos_reg, fpos_next;
    logic [15:0] pkt_left_reg, pkt_left_next;
    logic [7:0]  hdr_left_reg, hdr_left_next;
    logic [7:0]  flag_reg, flag_next;
    ts_t         pts_reg, pts_next;
    ts_t         dts_reg, dts_next;
    logic        have_ts_reg, have_ts_next;
    logic        first_reg, first_next;

    logic        out_valid_reg;
    logic [7:0]  payload_reg;
    logic        first_out_reg;
    logic        last_out_reg;
    logic        ts_valid_reg;
    ts_t         pts_out_reg;
    ts_t         dts_out_reg;

    logic        advance;
    logic        emit;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] pkt_dec;
        logic [7:0]  hdr_dec;
        logic        ts_do;
        logic        form_do;
        logic [3:0]  ts_need;
        logic [3:0]  ts_pos;
        logic [3:0]  pos_sub;

        b         = in_byte_reg;
        pkt_dec   = (pkt_left_reg != 16'd0) ? pkt_left_reg - 16'd1 : 16'd0;
        hdr_dec   = (hdr_left_reg != 8'd0) ? hdr_left_reg - 8'd1 : 8'd0;
        ts_do     = 1'b0;
        form_do   = 1'b0;
        ts_need   = NEED_NONE;
        ts_pos    = fpos_reg;
        pos_sub   = 4'd0;
        emit      = 1'b0;

        phase_next    = phase_reg;
        prefix_next   = prefix_reg;
        fpos_next     = fpos_reg;
        pkt_left_next = pkt_left_reg;
        hdr_left_next = hdr_left_reg;
        flag_next     = flag_reg;
        pts_next      = pts_reg;
        dts_next      = dts_reg;
        have_ts_next  = have_ts_reg;
        first_next    = first_reg;

        unique case (phase_reg)
            PH_CODE:
            begin
                if (b == PACK_START_CODE) begin
                    phase_next = PH_PACK1ST;
                end else if (b >= FIRST_STREAM_ID) begin
                    flag_next  = b;
                    phase_next = PH_LENHI;
                end else begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end
            end
            PH_PACK1ST:
            begin
                if ((b & HI2_MASK) == MPEG2_MARK) begin
                    hdr_left_next = 8'd9;
                    phase_next    = PH_PACK2;
                end else begin
                    hdr_left_next = 8'd7;
                    phase_next    = PH_PACKSKIP;
                end
            end
            PH_PACK2:
            begin
                hdr_left_next = hdr_left_reg - 8'd1;
                if (hdr_left_next == 8'd0) begin
                    hdr_left_next = {5'd0, b[2:0]};
                    if (b[2:0] == 3'd0) begin
                        phase_next  = PH_HUNT;
                        prefix_next = 2'd0;
                    end else begin
                        phase_next = PH_PACKSKIP;
                    end
                end
            end
            PH_PACKSKIP:
            begin
                hdr_left_next = hdr_dec;
                if (hdr_dec == 8'd0) begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end
            end
            PH_LENHI:
            begin
                pkt_left_next = {b, 8'd0};
                phase_next    = PH_LENLO;
            end
            PH_LENLO:
            begin
                pkt_left_next = {pkt_left_reg[15:8], b};
                if (pkt_left_next == 16'd0) begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end else if (flag_reg == target_reg) begin
                    have_ts_next = 1'b0;
                    first_next   = 1'b1;
                    fpos_next    = 4'd0;
                    phase_next   = PH_HDR1ST;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                pkt_left_next = pkt_dec;
                if (pkt_dec == 16'd0) begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end
            end
            PH_HDR1ST, PH_STD2, PH_AFTERSTD, PH_TS1,
            PH_M2FLAGS2, PH_M2HLEN, PH_M2HDR:
            begin
                pkt_left_next = pkt_dec;
                case (phase_reg)
                    PH_HDR1ST:
                    begin
                        if (b == STUFFING_BYTE) begin
                            phase_next = PH_HDR1ST;
                        end else if ((b & HI2_MASK) == STD_MARK) begin
                            phase_next = PH_STD2;
                        end else begin
                            form_do = 1'b1;
                        end
                    end
                    PH_STD2:
                    begin
                        phase_next = PH_AFTERSTD;
                    end
                    PH_AFTERSTD:
                    begin
                        form_do = 1'b1;
                    end
                    PH_TS1:
                    begin
                        ts_do   = 1'b1;
                        ts_need = ((flag_reg & HI4_MASK) == M1_PTSDTS_MARK) ?
                                  NEED_PTSDTS : NEED_PTS;
                        hdr_left_next = hdr_dec;
                        if (hdr_dec == 8'd0) begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_M2FLAGS2:
                    begin
                        flag_next  = b;
                        phase_next = PH_M2HLEN;
                    end
                    PH_M2HLEN:
                    begin
                        hdr_left_next = b;
                        fpos_next     = 4'd0;
                        phase_next    = (b == 8'd0) ? PH_PAYLOAD : PH_M2HDR;
                    end
                    default:
                    begin
                        ts_do = 1'b1;
                        if ((flag_reg & HI2_MASK) == M2_PTSDTS_FLAGS) begin
                            ts_need = NEED_PTSDTS;
                        end else if ((flag_reg & HI2_MASK) == M2_PTS_FLAGS) begin
                            ts_need = NEED_PTS;
                        end else begin
                            ts_need = NEED_NONE;
                        end
                        hdr_left_next = hdr_dec;
                        if (hdr_dec == 8'd0) begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                endcase

                if (form_do) begin
                    if ((b & HI4_MASK) == M1_PTS_MARK ||
                        (b & HI4_MASK) == M1_PTSDTS_MARK) begin
                        ts_do         = 1'b1;
                        ts_need       = ((b & HI4_MASK) == M1_PTSDTS_MARK) ?
                                        NEED_PTSDTS : NEED_PTS;
                        ts_pos        = 4'd0;
                        flag_next     = b;
                        hdr_left_next = {4'd0, ts_need - 4'd1};
                        phase_next    = PH_TS1;
                    end else if ((b & HI2_MASK) == M2_HDR_MARK) begin
                        phase_next = PH_M2FLAGS2;
                    end else if (b == MPEG1_NO_TS) begin
                        phase_next = PH_PAYLOAD;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end

                if (ts_do) begin
                    pos_sub = ts_pos - 4'd5;
                    if (ts_pos < ts_need) begin
                        if (ts_pos < 4'd5) begin
                            pts_next = ts_shift(pts_reg, ts_pos[2:0], b);
                        end else begin
                            dts_next = ts_shift(dts_reg, pos_sub[2:0], b);
                        end
                        if (ts_pos + 4'd1 == ts_need) begin
                            have_ts_next = 1'b1;
                            if (ts_need == NEED_PTS) begin
                                dts_next = pts_next;
                            end
                        end
                    end
                    fpos_next = (ts_pos < 4'd10) ? ts_pos + 4'd1 : ts_pos;
                end

                if (pkt_dec == 16'd0) begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end
            end
            PH_PAYLOAD:
            begin
                emit          = 1'b1;
                first_next    = 1'b0;
                pkt_left_next = pkt_dec;
                if (pkt_dec == 16'd0) begin
                    phase_next  = PH_HUNT;
                    prefix_next = 2'd0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (b == 8'd1 && prefix_reg == 2'd2) begin
                    phase_next  = PH_CODE;
                    prefix_next = 2'd0;
                end else if (b == 8'd0) begin
                    prefix_next = (prefix_reg < 2'd2) ? prefix_reg + 2'd1 : 2'd2;
                end else begin
                    prefix_next = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_reg    <= TARGET_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            prefix_reg    <= 2'd0;
            fpos_reg      <= 4'd0;
            pkt_left_reg  <= 16'd0;
            hdr_left_reg  <= 8'd0;
            flag_reg      <= 8'd0;
            pts_reg       <= '0;
            dts_reg       <= '0;
            have_ts_reg   <= 1'b0;
            first_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                phase_reg    <= phase_next;
                prefix_reg   <= prefix_next;
                fpos_reg     <= fpos_next;
                pkt_left_reg <= pkt_left_next;
                hdr_left_reg <= hdr_left_next;
                flag_reg     <= flag_next;
                pts_reg      <= pts_next;
                dts_reg      <= dts_next;
                have_ts_reg  <= have_ts_next;
                first_reg    <= first_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_byte_reg <= data_byte;
        end
        if (advance && emit) begin
            payload_reg   <= in_byte_reg;
            first_out_reg <= first_reg;
            last_out_reg  <= (pkt_left_reg <= 16'd1);
            ts_valid_reg  <= have_ts_reg;
            pts_out_reg   <= have_ts_reg ? pts_reg : '0;
            dts_out_reg   <= have_ts_reg ? dts_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign payload_byte      = payload_reg;
    assign packet_first      = first_out_reg;
    assign packet_last       = last_out_reg;
    assign timestamp_valid   = ts_valid_reg;
    assign presentation_time = pts_out_reg;
    assign decode_time       = dts_out_reg;

endmodule
